// ===== design/mgtp_pkg.sv =====
// ----------------------------------------------------------------------------
// mgtp_pkg
// Shared types and constants for the glyph to display byte packer.
// ----------------------------------------------------------------------------
package mgtp_pkg;

    // register field widths
    localparam int WIDTH_BITS  = 6;
    localparam int HEIGHT_BITS = 8;
    localparam int GATHER_BITS = 3;
    localparam int CFG_DATA_W  = 8;

    // configuration register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // register reset values
    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 6'd24;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 8'd20;

    // smallest width in pixels: one display byte per row
    localparam logic [6:0] MIN_WIDTH = 7'd3;

    // control from the row gatherer to the emit unit
    typedef struct packed {
        logic load;
        logic image_end;
    } t_emit_ctl;

    // three pixels, leftmost in bit 2, to display byte format
    function automatic logic [7:0] pix_map(input logic [2:0] code);
        logic [7:0] res;
        case (code)
            3'd0:    res = 8'h00;
            3'd1:    res = 8'hC0;
            3'd2:    res = 8'h1C;
            3'd3:    res = 8'hFC;
            3'd4:    res = 8'h03;
            3'd5:    res = 8'hE3;
            3'd6:    res = 8'h1F;
            3'd7:    res = 8'hFF;
            default: res = 8'h00;
        endcase
        return res;
    endfunction

endpackage

// ===== design/mono_glyph_to_triplet_pixel_bytes_core.sv =====
// ----------------------------------------------------------------------------
// mono_glyph_to_triplet_pixel_bytes_core
// Packs a 1-bit-per-pixel glyph bitmap into three-pixel display bytes.
// ----------------------------------------------------------------------------
// Bitmap bytes arrive MSB first, ceil(width/8) bytes per row. A byte that does
// not finish a row goes into the row register. The byte that finishes a row
// is taken, its row is left-aligned in a shift register, and then one 3-bit
// shift unit emits one display byte per cycle when the output is not stalled,
// while the input stalls; the next bitmap byte can be taken in the cycle after
// the last display byte of the row is loaded into the output register.
// Throughput is set by the emit shifter: no byte of the next row is taken while
// a row is emitted. Leftover pixels of a width that is not a multiple of three
// are dropped. Width is clamped to 3..MAX_ROW_BITS; a height of zero acts as
// one. Configuration must be written only while idle; the block does not enforce it.
module mono_glyph_to_triplet_pixel_bytes_core #(
    parameter int MAX_ROW_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [mgtp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_bitmap_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [7:0]                     o_display_byte,
    output logic                           o_last_of_row,
    output logic                           o_last_of_image
);
    import mgtp_pkg::*;

    localparam int ROW_BYTES = (MAX_ROW_BITS + 7) / 8;
    localparam int ROW_W     = ROW_BYTES * 8;
    localparam int WW        = $clog2(MAX_ROW_BITS + 1);

    logic [WIDTH_BITS-1:0]  r_width;
    logic [HEIGHT_BITS-1:0] r_height;
    logic [ROW_W-1:0]       r_row;
    logic [GATHER_BITS-1:0] r_bytes;
    logic [HEIGHT_BITS-1:0] r_rows;

    logic [6:0]             width_ext;
    logic [6:0]             width_clamp;
    logic [WW-1:0]          eff_width;
    logic [WW:0]            len_sum;
    logic [3:0]             row_len;
    logic [3:0]             bytes_next;
    logic                   row_done;
    logic                   image_end;
    logic [ROW_W-1:0]       row_data;
    logic [3:0]             pad_bytes;
    logic [6:0]             align_amt;
    logic [ROW_W-1:0]       row_aligned;
    logic                   in_take;
    logic                   busy;
    t_emit_ctl              emit_ctl;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WIDTH:  r_width  <= i_cfg_data[WIDTH_BITS-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[HEIGHT_BITS-1:0];
                default:    r_width  <= r_width;
            endcase
        end
    end

    // effective width and bytes per row
    always_comb begin
        width_ext = {1'b0, r_width};
        if (width_ext < MIN_WIDTH) begin
            width_clamp = MIN_WIDTH;
        end else if (width_ext > 7'(MAX_ROW_BITS)) begin
            width_clamp = 7'(MAX_ROW_BITS);
        end else begin
            width_clamp = width_ext;
        end
    end

    assign eff_width = WW'(width_clamp);
    assign len_sum   = {1'b0, eff_width} + (WW+1)'(7);
    assign row_len   = 4'(len_sum >> 3);

    // row gather and end detection
    assign in_take    = i_in_valid && !busy;
    assign bytes_next = {1'b0, r_bytes} + 4'd1;
    assign row_done   = bytes_next >= row_len;
    assign image_end  = ({1'b0, r_rows} + 9'd1) >= {1'b0, r_height};
    assign row_data   = ROW_W'({r_row, i_bitmap_byte});

    // left-align the row so its leftmost pixel sits in the top bit
    assign pad_bytes   = 4'(ROW_BYTES) - row_len;
    assign align_amt   = {pad_bytes, 3'b000};
    assign row_aligned = row_data << align_amt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_bytes <= '0;
            r_rows  <= '0;
        end else if (in_take) begin
            if (row_done) begin
                r_row   <= '0;
                r_bytes <= '0;
                r_rows  <= image_end ? '0 : r_rows + 8'd1;
            end else begin
                r_row   <= row_data;
                r_bytes <= r_bytes + 3'd1;
            end
        end
    end

    assign emit_ctl.load      = in_take && row_done;
    assign emit_ctl.image_end = image_end;

    // shared emit unit
    mgtp_emit #(
        .ROW_W (ROW_W),
        .WW    (WW)
    ) u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (emit_ctl),
        .i_row           (row_aligned),
        .i_width         (eff_width),
        .i_out_stall     (i_out_stall),
        .o_busy          (busy),
        .o_out_valid     (o_out_valid),
        .o_display_byte  (o_display_byte),
        .o_last_of_row   (o_last_of_row),
        .o_last_of_image (o_last_of_image)
    );

    assign o_in_stall = busy;

`ifndef SYNTHESIS
    // image end only on a row end
    a_img_on_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_of_image |-> o_last_of_row)
        else $error("last_of_image without last_of_row");

    // a finished row starts the emit unit
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_ctl.load |=> busy)
        else $error("row load did not start emit");

    // emit ends only with the last byte of a row in the output register
    a_end_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) && $past(i_rst_n) |-> o_out_valid && o_last_of_row)
        else $error("emit ended without last_of_row");
`endif

endmodule

// ===== design/mgtp_emit.sv =====
// ----------------------------------------------------------------------------
// mgtp_emit
// Shared 3-bit shift unit: walks a left-aligned pixel row three pixels per
// cycle while the output is not stalled and drives the output register.
// ----------------------------------------------------------------------------
module mgtp_emit #(
    parameter int ROW_W = 32,
    parameter int WW    = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mgtp_pkg::t_emit_ctl   i_ctl,
    input  logic [ROW_W-1:0]      i_row,
    input  logic [WW-1:0]         i_width,
    input  logic                  i_out_stall,
    output logic                  o_busy,
    output logic                  o_out_valid,
    output logic [7:0]            o_display_byte,
    output logic                  o_last_of_row,
    output logic                  o_last_of_image
);
    import mgtp_pkg::*;

    localparam logic [WW-1:0] STEP      = WW'(3);
    localparam logic [WW-1:0] LAST_EDGE = WW'(6);

    logic             r_busy;
    logic             r_out_valid;
    logic [ROW_W-1:0] r_shift;
    logic [WW-1:0]    r_remain;
    logic             r_img_end;
    logic [7:0]       r_byte;
    logic             r_last_row;
    logic             r_last_img;

    logic             n_busy;
    logic             n_out_valid;
    logic             slot_free;
    logic             emit;
    logic             last_group;

    // output slot is free when empty or being taken this cycle
    assign slot_free  = !r_out_valid || !i_out_stall;
    assign emit       = r_busy && slot_free;
    assign last_group = r_remain < LAST_EDGE;

    // sequencer next state
    always_comb begin
        n_busy      = r_busy;
        n_out_valid = r_out_valid;
        if (slot_free) begin
            n_out_valid = 1'b0;
        end
        if (emit) begin
            n_out_valid = 1'b1;
            if (last_group) begin
                n_busy = 1'b0;
            end
        end
        if (i_ctl.load) begin
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    // row shifter and output payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_shift   <= i_row;
            r_remain  <= i_width;
            r_img_end <= i_ctl.image_end;
        end else if (emit) begin
            r_shift  <= r_shift << 3;
            r_remain <= r_remain - STEP;
        end
        if (emit) begin
            r_byte     <= pix_map(r_shift[ROW_W-1 -: 3]);
            r_last_row <= last_group;
            r_last_img <= last_group && r_img_end;
        end
    end

    assign o_busy          = r_busy;
    assign o_out_valid     = r_out_valid;
    assign o_display_byte  = r_byte;
    assign o_last_of_row   = r_last_row;
    assign o_last_of_image = r_last_img;

endmodule
